### src/lnds_pkg.sv
// Package with the shared constants, types and state encoding of the subsequence core.
package lnds_pkg;

  localparam int unsigned MAX_LEN = 1024;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic read;
    logic compare;
    logic update;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic search_done;
    logic is_last;
    logic out_free;
  } dp_status_t;

endpackage

### src/lnds_if.sv
// Handshake interfaces for the input and result channels.
interface lnds_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [lnds_pkg::VALUE_W-1:0]    value;
  logic                                   last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface lnds_out_if;
  logic                           valid;
  logic                           ready;
  logic [lnds_pkg::LEN_W-1:0]     length;
  logic                           overflow;

  modport source (output valid, output length, output overflow, input ready);
  modport sink   (input valid, input length, input overflow, output ready);
endinterface

### src/lnds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lnds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/lnds_ctrl.sv
// Controller state machine sequencing the binary search, update and result hand-off.
module lnds_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lnds_pkg::dp_status_t status_i,
  output lnds_pkg::dp_cmd_t    cmd_o
);

  lnds_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lnds_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      lnds_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lnds_pkg::ST_SEARCH;
        end
      end
      lnds_pkg::ST_SEARCH: begin
        if (status_i.search_done) begin
          state_d = lnds_pkg::ST_UPDATE;
        end else begin
          cmd_o.read = 1'b1;
          state_d    = lnds_pkg::ST_COMPARE;
        end
      end
      lnds_pkg::ST_COMPARE: begin
        // The probed tail is now on the RAM output register.
        cmd_o.compare = 1'b1;
        state_d       = lnds_pkg::ST_SEARCH;
      end
      lnds_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = status_i.is_last ? lnds_pkg::ST_EMIT : lnds_pkg::ST_IDLE;
      end
      lnds_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = lnds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lnds_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### src/lnds_dp.sv
// Datapath: search bounds, tail count, overflow flag, tail store and result register.
module lnds_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [lnds_pkg::VALUE_W-1:0] value_i,
  input  logic                                last_item_i,
  input  lnds_pkg::dp_cmd_t                   cmd_i,
  output lnds_pkg::dp_status_t                status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lnds_pkg::LEN_W-1:0]          out_length_o,
  output logic                                out_overflow_o
);

  logic signed [lnds_pkg::VALUE_W-1:0] value_q;
  logic                                last_q;
  logic [lnds_pkg::CNT_W-1:0]          lo_q, hi_q, mid_q, count_q;
  logic [lnds_pkg::CNT_W-1:0]          mid_d;
  logic                                ovf_q;
  logic                                out_valid_q;
  logic [lnds_pkg::LEN_W-1:0]          out_len_q;
  logic                                out_ovf_q;
  logic signed [lnds_pkg::VALUE_W-1:0] rd_data;
  logic                                overwrite;
  logic                                full;
  logic                                wr_en;

  assign mid_d     = lo_q + ((hi_q - lo_q) >> 1);
  assign overwrite = (lo_q < count_q);
  assign full      = (count_q == lnds_pkg::CNT_W'(lnds_pkg::MAX_LEN));
  // When no tail is greater the search ends with lo equal to the count,
  // so the append address is lo as well.
  assign wr_en     = cmd_i.update && (overwrite || !full);

  lnds_ram #(
    .WIDTH (lnds_pkg::VALUE_W),
    .DEPTH (lnds_pkg::MAX_LEN)
  ) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (lo_q[lnds_pkg::ADDR_W-1:0]),
    .wdata_i (value_q),
    .raddr_i (mid_d[lnds_pkg::ADDR_W-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q     <= '0;
      last_q      <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_len_q   <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        value_q <= value_i;
        last_q  <= last_item_i;
        lo_q    <= '0;
        hi_q    <= count_q;
      end
      if (cmd_i.read) begin
        mid_q <= mid_d;
      end
      if (cmd_i.compare) begin
        if (rd_data > value_q) begin
          hi_q <= mid_q;
        end else begin
          lo_q <= mid_q + 1'b1;
        end
      end
      if (cmd_i.update && !overwrite) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        out_len_q   <= lnds_pkg::LEN_W'(count_q);
        out_ovf_q   <= ovf_q;
        count_q     <= '0;
        ovf_q       <= 1'b0;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.search_done = (lo_q >= hi_q);
  assign status_o.is_last     = last_q;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_length_o   = out_len_q;
  assign out_overflow_o = out_ovf_q;

endmodule

### src/longest_nondecreasing_subsequence_core.sv
// Top level of the longest non-decreasing subsequence core.
// The input channel takes one signed 32-bit value per transaction, with
// last_item marking the end of a sequence. For every value the core runs a
// binary search over its sorted store of tail values, held in a RAM with one
// write port, one read port and registered read, then overwrites or appends
// one tail. A search takes at most ceil(log2(n + 1)) steps, where n is the
// number of tails stored so far; each step costs one RAM read and one
// compare. An item marked last then passes through an emit step that loads
// the result register. The result channel carries length and overflow, one
// transaction per sequence; after that the tail count and overflow flag
// start from zero. The result register lets a new sequence begin while the
// previous result waits; if the receiver stalls, a last item waits for the
// register to free. Reset (rst_ni low, asynchronous) empties the store and
// clears any result.
module longest_nondecreasing_subsequence_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  lnds_in_if.sink    in_if,
  lnds_out_if.source out_if
);

  lnds_pkg::dp_cmd_t    cmd;
  lnds_pkg::dp_status_t status;
  logic                 in_ready;

  lnds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lnds_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (in_if.value),
    .last_item_i    (in_if.last_item),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .out_length_o   (out_if.length),
    .out_overflow_o (out_if.overflow)
  );

  assign in_if.ready = in_ready;

endmodule

### src/lnds_checker.sv
// Port-level checker for the subsequence core, bound to the top level.
module lnds_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [lnds_pkg::LEN_W-1:0] out_length_i,
  input logic                       out_overflow_i
);

  // A stalled result must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_length_i) && $stable(out_overflow_i))
    else $error("result changed while stalled");

  // The core works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while an item is in progress");

  // A new result only comes out of the emit step, never while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without an item in progress");

  // An overflow can only happen once the store is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_overflow_i |->
      out_length_i == lnds_pkg::LEN_W'(lnds_pkg::MAX_LEN))
    else $error("overflow reported with a store that was not full");

endmodule

bind longest_nondecreasing_subsequence_core lnds_checker u_lnds_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_if.valid),
  .in_ready_i     (in_if.ready),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .out_length_i   (out_if.length),
  .out_overflow_i (out_if.overflow)
);
